>>> rtl/aesp_pkg.sv
// Shared types, constants and helper functions of the escape sequence parser.
`timescale 1ns / 1ps
package aesp_pkg;

	localparam int QDEPTH_DEF = 4;

	localparam logic [14:0] WIDTH_RST  = 15'd80;
	localparam logic [14:0] HEIGHT_RST = 15'd25;
	localparam logic [15:0] ATTR_RST   = 16'h0007;

	// config register indexes
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	// result actions
	localparam logic [1:0] ACT_PRINT = 2'd0;
	localparam logic [1:0] ACT_ATTR  = 2'd1;
	localparam logic [1:0] ACT_MOVE  = 2'd2;
	localparam logic [1:0] ACT_CLEAR = 2'd3;

	// byte values
	localparam logic [7:0] CH_ESC   = 8'd27;
	localparam logic [7:0] CH_LBRK  = 8'h5B;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SGR   = 8'h6D;
	localparam logic [7:0] CH_UP    = 8'h41;
	localparam logic [7:0] CH_DOWN  = 8'h42;
	localparam logic [7:0] CH_FWD   = 8'h43;
	localparam logic [7:0] CH_BACK  = 8'h44;
	localparam logic [7:0] CH_HOME  = 8'h48;
	localparam logic [7:0] CH_HOMEF = 8'h66;
	localparam logic [7:0] CH_SAVE  = 8'h73;
	localparam logic [7:0] CH_REST  = 8'h75;
	localparam logic [7:0] CH_ERASE = 8'h4A;

	// byte classes
	typedef logic [3:0] cls_t;
	localparam cls_t CLS_OTHER = 4'd0;
	localparam cls_t CLS_DIGIT = 4'd1;
	localparam cls_t CLS_SEMI  = 4'd2;
	localparam cls_t CLS_ESC   = 4'd3;
	localparam cls_t CLS_LBRK  = 4'd4;
	localparam cls_t CLS_SGR   = 4'd5;
	localparam cls_t CLS_UP    = 4'd6;
	localparam cls_t CLS_DOWN  = 4'd7;
	localparam cls_t CLS_FWD   = 4'd8;
	localparam cls_t CLS_BACK  = 4'd9;
	localparam cls_t CLS_HOME  = 4'd10;
	localparam cls_t CLS_SAVE  = 4'd11;
	localparam cls_t CLS_REST  = 4'd12;
	localparam cls_t CLS_ERASE = 4'd13;

	// SGR codes and masks
	localparam logic [15:0] SGR_RESET   = 16'd0;
	localparam logic [15:0] SGR_BOLD    = 16'd1;
	localparam logic [15:0] SGR_UNDER   = 16'd4;
	localparam logic [15:0] SGR_REVERSE = 16'd7;
	localparam logic [15:0] SGR_FG_LO   = 16'd30;
	localparam logic [15:0] SGR_FG_HI   = 16'd37;
	localparam logic [15:0] SGR_FG_DEF  = 16'd39;
	localparam logic [15:0] SGR_BG_LO   = 16'd40;
	localparam logic [15:0] SGR_BG_HI   = 16'd47;
	localparam logic [15:0] SGR_BG_DEF  = 16'd49;
	localparam logic [15:0] BOLD_BITS   = 16'h0088;
	localparam logic [15:0] UNDER_BIT   = 16'h8000;
	localparam logic [15:0] MASK_FG     = 16'h00F8;
	localparam logic [15:0] MASK_BG     = 16'h008F;
	localparam logic [15:0] MASK_FG_DEF = 16'h00F7;
	localparam logic [15:0] MASK_BG_DEF = 16'h007F;
	localparam logic [15:0] NUM_MOD     = 16'hFFFF;

	// classified byte as it travels through the queue
	typedef struct packed {
		cls_t        cls;
		logic [3:0]  digit;
		logic [7:0]  data;
		logic [14:0] col;
		logic [14:0] row;
	} aesp_item_t;

	function automatic cls_t classify(input logic [7:0] b);
		cls_t c;
		c = CLS_OTHER;
		if (b >= CH_ZERO && b <= CH_NINE) c = CLS_DIGIT;
		else if (b == CH_SEMI) c = CLS_SEMI;
		else if (b == CH_ESC) c = CLS_ESC;
		else if (b == CH_LBRK) c = CLS_LBRK;
		else if (b == CH_SGR) c = CLS_SGR;
		else if (b == CH_UP) c = CLS_UP;
		else if (b == CH_DOWN) c = CLS_DOWN;
		else if (b == CH_FWD) c = CLS_FWD;
		else if (b == CH_BACK) c = CLS_BACK;
		else if (b == CH_HOME || b == CH_HOMEF) c = CLS_HOME;
		else if (b == CH_SAVE) c = CLS_SAVE;
		else if (b == CH_REST) c = CLS_REST;
		else if (b == CH_ERASE) c = CLS_ERASE;
		return c;
	endfunction

	// (v*10 + d) mod 65535, folding the high part back: 2^16 == 1 mod 65535
	function automatic logic [15:0] accum(input logic [15:0] v, input logic [3:0] d);
		logic [19:0] x;
		logic [16:0] s;
		x = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {16'd0, d};
		s = {13'd0, x[19:16]} + {1'b0, x[15:0]};
		if (s >= {1'b0, NUM_MOD}) s = s - {1'b0, NUM_MOD};
		return s[15:0];
	endfunction

	// ANSI color index to PC color bits
	function automatic logic [2:0] color_map(input logic [2:0] i);
		logic [2:0] r;
		unique case (i)
			3'd0: r = 3'd0;
			3'd1: r = 3'd4;
			3'd2: r = 3'd2;
			3'd3: r = 3'd6;
			3'd4: r = 3'd1;
			3'd5: r = 3'd5;
			3'd6: r = 3'd3;
			3'd7: r = 3'd7;
			default: r = 3'd0;
		endcase
		return r;
	endfunction

	function automatic logic [15:0] sgr_apply(input logic [15:0] a, input logic [15:0] code);
		logic [15:0] r;
		r = code; // unknown code: attribute takes the code itself
		if (code == SGR_RESET) r = ATTR_RST;
		else if (code == SGR_BOLD) r = a | BOLD_BITS;
		else if (code == SGR_UNDER) r = a | UNDER_BIT;
		else if (code == SGR_REVERSE) r = {8'h00, a[3:0], a[7:4]};
		else if (code >= SGR_FG_LO && code <= SGR_FG_HI)
			r = (a & MASK_FG) | {13'd0, color_map(code[2:0] - 3'd6)};
		else if (code == SGR_FG_DEF) r = a & MASK_FG_DEF;
		else if (code >= SGR_BG_LO && code <= SGR_BG_HI)
			r = (a & MASK_BG) | {9'd0, color_map(code[2:0]), 4'd0};
		else if (code == SGR_BG_DEF) r = a & MASK_BG_DEF;
		return r;
	endfunction

endpackage

>>> rtl/aesp_front.sv
// Front stage: accepts input bytes and classifies them.
`timescale 1ns / 1ps
module aesp_front import aesp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic [14:0] cursor_col,
	input  logic [14:0] cursor_row,
	output logic        push,
	output aesp_item_t  push_item,
	input  logic        q_full
);

	logic       valid_s1;
	aesp_item_t item_s1;

	assign push      = valid_s1 && !q_full;
	assign push_item = item_s1;
	assign in_ready  = !valid_s1 || !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.cls   <= classify(data_byte);
			item_s1.digit <= data_byte[3:0];
			item_s1.data  <= data_byte;
			item_s1.col   <= cursor_col;
			item_s1.row   <= cursor_row;
		end
	end

endmodule

>>> rtl/aesp_queue.sv
// Short FIFO between front and back stages.
`timescale 1ns / 1ps
module aesp_queue import aesp_pkg::*; #(
	parameter int DEPTH = QDEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  aesp_item_t push_item,
	output logic       full,
	input  logic       pop,
	output logic       not_empty,
	output aesp_item_t head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	aesp_item_t       mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full      = (cnt_q == CNT_W'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign head      = mem_q[rd_q];

	function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= bump(wr_q);
			if (pop) rd_q <= bump(rd_q);
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_item;
	end

endmodule

>>> rtl/aesp_back.sv
// Back stage: escape sequence state machine, attribute state and result register.
`timescale 1ns / 1ps
module aesp_back import aesp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_not_empty,
	input  aesp_item_t  item,
	output logic        pop,
	input  logic [14:0] screen_width,
	input  logic [14:0] screen_height,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  action,
	output logic [7:0]  char_out,
	output logic [15:0] attr_out,
	output logic [15:0] new_col,
	output logic [15:0] new_row
);

	localparam logic [2:0] MODE_IDLE = 3'd0;
	localparam logic [2:0] MODE_ESC  = 3'd1;
	localparam logic [2:0] MODE_N1S  = 3'd2;
	localparam logic [2:0] MODE_N1   = 3'd3;
	localparam logic [2:0] MODE_N2S  = 3'd4;
	localparam logic [2:0] MODE_N2   = 3'd5;

	logic [2:0]  mode_q, mode_nx;
	logic [15:0] n1_q, n1_nx, n2_q, n2_nx;
	logic [15:0] attr_q, attr_nx;
	logic [15:0] scol_q, scol_nx, srow_q, srow_nx;

	logic        out_valid_q;
	logic [1:0]  action_q;
	logic [7:0]  char_q;
	logic [15:0] attr_out_q, col_q, row_q;

	logic        emit, idle_path;
	logic [1:0]  act;
	logic [7:0]  ch;
	logic [15:0] ocol, orow;

	logic [15:0] acc1, acc2, sgr1, sgr2;
	logic [15:0] col16, row16;
	logic [16:0] row_sum, col_sum;
	logic [15:0] up_row, down_row, fwd_col, back_col;

	assign pop = q_not_empty && (!out_valid_q || out_ready);

	assign acc1 = accum(n1_q, item.digit);
	assign acc2 = accum(n2_q, item.digit);
	assign sgr1 = sgr_apply(attr_q, n1_q);
	assign sgr2 = sgr_apply(sgr1, n2_q);

	// relative moves, clamped at zero or at the screen size
	assign col16    = {1'b0, item.col};
	assign row16    = {1'b0, item.row};
	assign row_sum  = {1'b0, row16} + {1'b0, n1_q};
	assign col_sum  = {1'b0, col16} + {1'b0, n1_q};
	assign up_row   = (row16 > n1_q) ? row16 - n1_q : '0;
	assign back_col = (col16 > n1_q) ? col16 - n1_q : '0;
	assign down_row = (row_sum < {2'b00, screen_height}) ? row_sum[15:0] : {1'b0, screen_height};
	assign fwd_col  = (col_sum < {2'b00, screen_width}) ? col_sum[15:0] : {1'b0, screen_width};

	always_comb begin
		mode_nx   = mode_q;
		n1_nx     = n1_q;
		n2_nx     = n2_q;
		attr_nx   = attr_q;
		scol_nx   = scol_q;
		srow_nx   = srow_q;
		emit      = 1'b0;
		act       = ACT_PRINT;
		ch        = '0;
		ocol      = '0;
		orow      = '0;
		idle_path = 1'b0;
		unique case (mode_q)
			MODE_ESC: begin
				if (item.cls == CLS_LBRK) begin
					n1_nx   = '0;
					n2_nx   = '0;
					mode_nx = MODE_N1S;
				end else begin
					idle_path = 1'b1; // ESC dropped, byte handled as plain
				end
			end
			MODE_N1S: begin
				if (item.cls == CLS_DIGIT) begin
					n1_nx   = acc1;
					mode_nx = MODE_N1;
				end else if (item.cls != CLS_SEMI) begin
					mode_nx = MODE_IDLE;
					if (item.cls == CLS_SAVE) begin
						scol_nx = col16;
						srow_nx = row16;
					end else if (item.cls == CLS_REST) begin
						emit = 1'b1;
						act  = ACT_MOVE;
						ocol = scol_q;
						orow = srow_q;
					end else if (item.cls == CLS_HOME) begin
						emit = 1'b1;
						act  = ACT_MOVE;
					end
				end
			end
			MODE_N1: begin
				if (item.cls == CLS_DIGIT) begin
					n1_nx = acc1;
				end else if (item.cls == CLS_SEMI) begin
					mode_nx = MODE_N2S;
				end else begin
					mode_nx = MODE_IDLE;
					if (item.cls == CLS_SGR) begin
						attr_nx = sgr1;
						emit    = 1'b1;
						act     = ACT_ATTR;
					end else if (item.cls == CLS_UP) begin
						emit = 1'b1;
						act  = ACT_MOVE;
						ocol = col16;
						orow = up_row;
					end else if (item.cls == CLS_DOWN) begin
						emit = 1'b1;
						act  = ACT_MOVE;
						ocol = col16;
						orow = down_row;
					end else if (item.cls == CLS_FWD) begin
						emit = 1'b1;
						act  = ACT_MOVE;
						ocol = fwd_col;
						orow = row16;
					end else if (item.cls == CLS_BACK) begin
						emit = 1'b1;
						act  = ACT_MOVE;
						ocol = back_col;
						orow = row16;
					end else if (item.cls == CLS_ERASE && n1_q == 16'd2) begin
						emit = 1'b1;
						act  = ACT_CLEAR;
					end
				end
			end
			MODE_N2S: begin
				if (item.cls == CLS_DIGIT) begin
					n2_nx   = acc2;
					mode_nx = MODE_N2;
				end else if (item.cls != CLS_SEMI) begin
					mode_nx = MODE_IDLE;
				end
			end
			MODE_N2: begin
				if (item.cls == CLS_DIGIT) begin
					n2_nx = acc2;
				end else if (item.cls == CLS_SGR || item.cls == CLS_SEMI) begin
					attr_nx = sgr2;
					emit    = 1'b1;
					act     = ACT_ATTR;
					if (item.cls == CLS_SEMI) begin
						// chained SGR pair: restart at a fresh first number
						n1_nx   = '0;
						n2_nx   = '0;
						mode_nx = MODE_N1S;
					end else begin
						mode_nx = MODE_IDLE;
					end
				end else begin
					mode_nx = MODE_IDLE;
					if (item.cls == CLS_HOME) begin
						emit = 1'b1;
						act  = ACT_MOVE;
						ocol = n2_q;
						orow = n1_q;
					end
				end
			end
			default: idle_path = 1'b1;
		endcase
		if (idle_path) begin
			if (item.cls == CLS_ESC) begin
				mode_nx = MODE_ESC;
			end else begin
				mode_nx = MODE_IDLE;
				emit    = 1'b1;
				act     = ACT_PRINT;
				ch      = item.data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_IDLE;
			n1_q        <= '0;
			n2_q        <= '0;
			attr_q      <= ATTR_RST;
			scol_q      <= '0;
			srow_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				mode_q <= mode_nx;
				n1_q   <= n1_nx;
				n2_q   <= n2_nx;
				attr_q <= attr_nx;
				scol_q <= scol_nx;
				srow_q <= srow_nx;
			end
			if (pop && emit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			action_q   <= act;
			char_q     <= ch;
			attr_out_q <= attr_nx;
			col_q      <= ocol;
			row_q      <= orow;
		end
	end

	assign out_valid = out_valid_q;
	assign action    = action_q;
	assign char_out  = char_q;
	assign attr_out  = attr_out_q;
	assign new_col   = col_q;
	assign new_row   = row_q;

endmodule

>>> rtl/ansi_escape_sequence_parser.sv
// Top level of the ANSI escape sequence parser.
`timescale 1ns / 1ps
// Usage:
//  - Input channel (in_valid/in_ready): one text byte per transfer, with the
//    display cursor position seen before that byte.
//  - Output channel (out_valid/out_ready): zero or one result per input byte:
//    print, set attribute, move cursor, or clear screen. Bytes inside an
//    escape sequence produce no result until the final byte or an SGR pair's ';'.
//  - Config port: cfg_we with cfg_index 0 writes the screen width, index 1
//    the screen height. Write only while no byte is in flight.
//  - Path: a byte is classified into the front register, passes the queue,
//    and its result is popped into the output register.
//  - Throughput: one byte per cycle while out_ready stays high; the back stage
//    updates the parser state for every popped byte, so nothing else limits it.
//  - Stalls: when out_ready is low, the output register holds its result and
//    the queue (QDEPTH entries) plus the front register absorb further bytes;
//    in_ready drops only once both are full.
//  - Reset: arst_n clears parser state, attribute (0x0007), saved cursor,
//    queue and output valid; width/height return to 80x25.
module ansi_escape_sequence_parser import aesp_pkg::*; #(
	parameter int QDEPTH = QDEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic [14:0] cursor_col,
	input  logic [14:0] cursor_row,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  action,
	output logic [7:0]  char_out,
	output logic [15:0] attr_out,
	output logic [15:0] new_col,
	output logic [15:0] new_row,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [14:0] cfg_data
);

	logic [14:0] width_q, height_q;

	logic       push, q_full, q_not_empty, pop;
	aesp_item_t push_item, head;

	// screen size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	aesp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.cursor_col (cursor_col),
		.cursor_row (cursor_row),
		.push       (push),
		.push_item  (push_item),
		.q_full     (q_full)
	);

	aesp_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_not_empty),
		.head      (head)
	);

	aesp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_not_empty   (q_not_empty),
		.item          (head),
		.pop           (pop),
		.screen_width  (width_q),
		.screen_height (height_q),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.action        (action),
		.char_out      (char_out),
		.attr_out      (attr_out),
		.new_col       (new_col),
		.new_row       (new_row)
	);

endmodule

>>> sim/ansi_escape_sequence_parser_tb.sv
// Self-checking testbench for the ANSI escape sequence parser: random byte streams vs a model.
`timescale 1ns / 1ps
module ansi_escape_sequence_parser_tb;
	import aesp_pkg::*;

	// Erase-in-line final byte: a valid CSI final that the parser ignores.
	localparam logic [7:0] CH_ERASE_LINE = 8'h4B;

	localparam int unsigned PHASE_BYTES = 305;
	localparam int unsigned NUM_PHASES  = 6;
	localparam int unsigned HOLD_LEN    = 400;
	// Generous limit: the slowest correct run ends far sooner.
	localparam int unsigned CYCLE_LIMIT = 500000;

	typedef enum logic [2:0] {
		PM_IDLE,   // plain text
		PM_ESC,    // ESC seen, waiting for '['
		PM_CSI,    // inside CSI, no digit yet
		PM_NUM1,   // collecting the first number
		PM_SEP,    // ';' after first number, no digit yet
		PM_NUM2    // collecting the second number
	} parse_mode_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [7:0]  ch;
		logic [15:0] attr;
		logic [15:0] col;
		logic [15:0] row;
	} disp_result_t;

	// Tracks the parser state, predicts one display result per byte (or none)
	// and checks the results leaving the block in order.
	class vt_scoreboard;
		int unsigned  width;
		int unsigned  height;
		parse_mode_t  mode;
		int unsigned  num1;
		int unsigned  num2;
		logic [15:0]  attr;
		logic [15:0]  saved_col;
		logic [15:0]  saved_row;
		disp_result_t pending[$];
		int unsigned  errors;
		int unsigned  per_action[4];

		function new();
			width     = WIDTH_RST;
			height    = HEIGHT_RST;
			mode      = PM_IDLE;
			num1      = 0;
			num2      = 0;
			attr      = ATTR_RST;
			saved_col = '0;
			saved_row = '0;
			errors    = 0;
			foreach (per_action[i]) per_action[i] = 0;
		endfunction

		// Decimal accumulation, wrapping modulo 65535.
		function int unsigned next_num(int unsigned v, logic [7:0] b);
			return (v * 10 + int'(b - CH_ZERO)) % 65535;
		endfunction

		// ANSI color order (R,G,B bit order) to PC attribute order: bit reverse.
		function logic [2:0] ansi_to_pc(logic [2:0] i);
			return {i[0], i[1], i[2]};
		endfunction

		function logic [15:0] apply_sgr(logic [15:0] a, int unsigned code);
			if (code == SGR_RESET) return ATTR_RST;
			if (code == SGR_BOLD) return a | 16'h0088;
			if (code == SGR_UNDER) return a | 16'h8000;
			// reverse swaps fg/bg nibbles and drops the high byte
			if (code == SGR_REVERSE) return {8'h00, a[3:0], a[7:4]};
			if (code >= SGR_FG_LO && code <= SGR_FG_HI)
				return (a & 16'h00F8) | 16'(ansi_to_pc(3'(code - SGR_FG_LO)));
			if (code == SGR_FG_DEF) return a & 16'h00F7;
			if (code >= SGR_BG_LO && code <= SGR_BG_HI)
				return (a & 16'h008F) | {9'd0, ansi_to_pc(3'(code - SGR_BG_LO)), 4'd0};
			if (code == SGR_BG_DEF) return a & 16'h007F;
			// anything else simply becomes the attribute
			return 16'(code);
		endfunction

		// One accepted input transfer.
		function void take_byte(logic [7:0] b, logic [14:0] col, logic [14:0] row);
			disp_result_t r;
			bit digit;
			bit hit;
			bit plain;
			int unsigned c;
			int unsigned rw;
			int unsigned v;
			r = '0;
			hit = 0;
			plain = 0;
			digit = (b >= CH_ZERO) && (b <= CH_NINE);
			c = col;
			rw = row;
			v = num1;
			case (mode)
			PM_ESC: begin
				if (b == CH_LBRK) begin
					num1 = 0;
					num2 = 0;
					mode = PM_CSI;
				end else
					plain = 1;   // ESC is dropped, byte handled as plain text
			end
			PM_CSI: begin
				if (digit) begin
					num1 = next_num(num1, b);
					mode = PM_NUM1;
				end else if (b != CH_SEMI) begin
					mode = PM_IDLE;
					if (b == CH_SAVE) begin
						saved_col = 16'(col);
						saved_row = 16'(row);
					end else if (b == CH_REST) begin
						hit = 1;
						r.action = ACT_MOVE;
						r.col = saved_col;
						r.row = saved_row;
					end else if (b == CH_HOME || b == CH_HOMEF) begin
						hit = 1;
						r.action = ACT_MOVE;
					end
				end
			end
			PM_NUM1: begin
				if (digit)
					num1 = next_num(num1, b);
				else if (b == CH_SEMI)
					mode = PM_SEP;
				else begin
					mode = PM_IDLE;
					hit = 1;
					r.action = ACT_MOVE;
					r.col = 16'(c);
					r.row = 16'(rw);
					case (b)
					CH_SGR: begin
						attr = apply_sgr(attr, v);
						r.action = ACT_ATTR;
						r.col = '0;
						r.row = '0;
					end
					CH_UP: r.row = 16'(rw > v ? rw - v : 0);
					CH_DOWN: r.row = 16'(rw + v < height ? rw + v : height);
					CH_FWD: r.col = 16'(c + v < width ? c + v : width);
					CH_BACK: r.col = 16'(c > v ? c - v : 0);
					CH_ERASE: begin
						r.action = ACT_CLEAR;
						r.col = '0;
						r.row = '0;
						hit = (v == 2);
					end
					default: hit = 0;
					endcase
				end
			end
			PM_SEP: begin
				if (digit) begin
					num2 = next_num(num2, b);
					mode = PM_NUM2;
				end else if (b != CH_SEMI)
					mode = PM_IDLE;
			end
			PM_NUM2: begin
				if (digit)
					num2 = next_num(num2, b);
				else if (b == CH_SGR || b == CH_SEMI) begin
					attr = apply_sgr(apply_sgr(attr, num1), num2);
					hit = 1;
					r.action = ACT_ATTR;
					// a trailing ';' starts a fresh pair
					if (b == CH_SEMI) begin
						num1 = 0;
						num2 = 0;
						mode = PM_CSI;
					end else
						mode = PM_IDLE;
				end else begin
					mode = PM_IDLE;
					if (b == CH_HOME || b == CH_HOMEF) begin
						hit = 1;
						r.action = ACT_MOVE;
						r.col = 16'(num2);
						r.row = 16'(num1);
					end
				end
			end
			default: plain = 1;
			endcase
			if (plain) begin
				if (b == CH_ESC)
					mode = PM_ESC;
				else begin
					mode = PM_IDLE;
					hit = 1;
					r.action = ACT_PRINT;
					r.ch = b;
				end
			end
			if (hit) begin
				r.attr = attr;
				pending.push_back(r);
			end
		endfunction

		function void check_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				errors++;
				$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
			end
		endfunction

		// One accepted output transfer.
		function void match_result(disp_result_t got);
			disp_result_t want;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none actual %h", $time, got);
				return;
			end
			want = pending.pop_front();
			per_action[want.action]++;
			check_field("action", want.action, got.action);
			check_field("char_out", want.ch, got.ch);
			check_field("attr_out", want.attr, got.attr);
			check_field("new_col", want.col, got.col);
			check_field("new_row", want.row, got.row);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  data_byte;
	logic [14:0] cursor_col;
	logic [14:0] cursor_row;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  action;
	logic [7:0]  char_out;
	logic [15:0] attr_out;
	logic [15:0] new_col;
	logic [15:0] new_row;
	logic        cfg_we;
	logic        cfg_index;
	logic [14:0] cfg_data;

	vt_scoreboard sb;
	int unsigned  send_idle_pct;
	int unsigned  recv_stall_pct;
	int unsigned  hold_cycles;
	int unsigned  cycle_count;
	int unsigned  bytes_sent;

	ansi_escape_sequence_parser u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.cursor_col(cursor_col),
		.cursor_row(cursor_row),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.action    (action),
		.char_out  (char_out),
		.attr_out  (attr_out),
		.new_col   (new_col),
		.new_row   (new_row),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout at cycle %0d, %0d results outstanding", cycle_count,
				sb.pending.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Receiver: stalls at random at the phase rate; a hold request keeps out_ready
	// low until hold_cycles counts down to zero, so the internal queue backs up.
	always @(negedge clk) begin
		if (hold_cycles != 0) begin
			out_ready <= 1'b0;
			hold_cycles--;
		end else
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Monitor: both channels sampled at the rising edge. A result leaving now
	// always belongs to an earlier input transfer, so check before predicting.
	always @(posedge clk) begin
		disp_result_t seen;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				seen = {action, char_out, attr_out, new_col, new_row};
				sb.match_result(seen);
			end
			if (in_valid && in_ready)
				sb.take_byte(data_byte, cursor_col, cursor_row);
		end
	end

	// Mostly small cursor values so clamps trigger, plus both ends of the range.
	function automatic logic [14:0] pick_coord();
		case ($urandom_range(7))
		0: return 15'd0;
		1: return 15'h7FFF;
		2, 3: return 15'($urandom);
		default: return 15'($urandom_range(100));
		endcase
	endfunction

	// Decimal parameter text: small, full 16-bit, above 16-bit, leading zeros, or a
	// long run that wraps the accumulator several times.
	function automatic string num_text();
		case ($urandom_range(9))
		0, 1, 2, 3, 4: return $sformatf("%0d", $urandom_range(40));
		5, 6: return $sformatf("%0d", $urandom_range(65535));
		7: return $sformatf("%0d", $urandom_range(999999, 65535));
		8: return $sformatf("00%0d", $urandom_range(9));
		default: return $sformatf("%0d%0d", $urandom, $urandom);
		endcase
	endfunction

	function automatic string sgr_text();
		case ($urandom_range(11))
		0: return $sformatf("%0d", SGR_RESET);
		1: return $sformatf("%0d", SGR_BOLD);
		2: return $sformatf("%0d", SGR_UNDER);
		3: return $sformatf("%0d", SGR_REVERSE);
		4, 5: return $sformatf("%0d", SGR_FG_LO + $urandom_range(7));
		6: return $sformatf("%0d", SGR_FG_DEF);
		7, 8: return $sformatf("%0d", SGR_BG_LO + $urandom_range(7));
		9: return $sformatf("%0d", SGR_BG_DEF);
		default: return num_text();
		endcase
	endfunction

	// Input transfer with random idle cycles in front; valid stays up until
	// the transfer completes.
	task automatic send_byte_at(input logic [7:0] b, input logic [14:0] col,
			input logic [14:0] row);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		data_byte  <= b;
		cursor_col <= col;
		cursor_row <= row;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		bytes_sent++;
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_byte_at(b, pick_coord(), pick_coord());
	endtask

	task automatic send_str(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	task automatic send_csi(input string body);
		send_byte(CH_ESC);
		send_byte(CH_LBRK);
		send_str(body);
	endtask

	// Mostly well-formed control sequences with random parameters; the rest is
	// plain text and broken or truncated sequences.
	task automatic send_random_sequence();
		int unsigned n;
		string body;
		logic [7:0] fin;
		case ($urandom_range(99)) inside
		[0:24]: begin
			repeat ($urandom_range(4, 1)) send_byte(8'($urandom_range(255)));
		end
		[25:44]: begin
			// SGR chain; every second code closes a pair and emits, as does a lone last code
			n = $urandom_range(4);
			body = "";
			for (int k = 0; k < n; k++) begin
				if (k != 0) body = $sformatf("%s%c", body, CH_SEMI);
				if (k != 0 && $urandom_range(9) == 0) body = $sformatf("%s%c", body, CH_SEMI);
				body = {body, sgr_text()};
			end
			send_csi($sformatf("%s%c", body, CH_SGR));
		end
		[45:64]: begin
			case ($urandom_range(3))
			0: fin = CH_UP;
			1: fin = CH_DOWN;
			2: fin = CH_FWD;
			default: fin = CH_BACK;
			endcase
			body = ($urandom_range(9) == 0) ? "" : num_text();
			send_csi($sformatf("%s%c", body, fin));
		end
		[65:74]: begin
			case ($urandom_range(5))
			0: body = "";
			1: body = num_text();
			2, 3: body = $sformatf("%s%c%s", num_text(), CH_SEMI, num_text());
			4: body = $sformatf("%c%s", CH_SEMI, num_text());
			default: body = $sformatf("%s%c", num_text(), CH_SEMI);
			endcase
			fin = $urandom_range(1) ? CH_HOME : CH_HOMEF;
			send_csi($sformatf("%s%c", body, fin));
		end
		[75:82]: begin
			body = ($urandom_range(4) == 0) ? num_text() : "";
			fin = $urandom_range(1) ? CH_SAVE : CH_REST;
			send_csi($sformatf("%s%c", body, fin));
		end
		[83:88]: begin
			case ($urandom_range(5))
			0, 1, 2: body = $sformatf("2%c", CH_ERASE);
			3: body = $sformatf("%s%c", num_text(), CH_ERASE);
			4: body = $sformatf("%c", CH_ERASE);
			default: body = $sformatf("2%c", CH_ERASE_LINE);
			endcase
			send_csi(body);
		end
		default: begin
			case ($urandom_range(3))
			0: begin
				send_byte(CH_ESC);
				send_byte(8'($urandom_range(255)));
			end
			1: begin
				send_byte(CH_ESC);
				send_byte(CH_LBRK);
				repeat ($urandom_range(3, 1)) send_byte(8'($urandom_range(255)));
			end
			2: send_csi($sformatf("%s%c%c", num_text(), CH_SEMI, 8'($urandom_range(255))));
			default: begin
				// ESC ESC '[' : the second ESC re-arms
				send_byte(CH_ESC);
				send_csi($sformatf("%s%c", num_text(), CH_FWD));
			end
			endcase
		end
		endcase
	endtask

	// Register write; the model is updated at once since nothing is in flight.
	task automatic write_reg(input logic idx, input logic [14:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		if (idx == REG_WIDTH)
			sb.width = val;
		else
			sb.height = val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Wait for every expected result, then let bytes that produce nothing
	// drain out of the queue before touching the registers.
	task automatic drain();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		int unsigned w;
		int unsigned h;
		int unsigned idle_in;
		int unsigned stall_out;
		int unsigned hold;
		int unsigned phase_start;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		data_byte      = '0;
		cursor_col     = '0;
		cursor_row     = '0;
		out_ready      = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = REG_WIDTH;
		cfg_data       = '0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_cycles    = 0;
		cycle_count    = 0;
		bytes_sent     = 0;
		sb = new();

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			hold = 0;
			case (ph)
			0: begin
				w = WIDTH_RST; h = HEIGHT_RST; idle_in = 0; stall_out = 0;
			end
			1: begin
				w = 1; h = 1; idle_in = 72; stall_out = 0;
			end
			2: begin
				w = 32767; h = 32767; idle_in = 0; stall_out = 72;
			end
			3: begin
				w = $urandom_range(32767, 1); h = $urandom_range(32767, 1);
				idle_in = 26; stall_out = 26;
			end
			4: begin
				// output held off for a long stretch while input keeps coming
				w = $urandom_range(200, 1); h = $urandom_range(200, 1);
				idle_in = 0; stall_out = 0; hold = HOLD_LEN;
			end
			default: begin
				w = $urandom_range(120, 1); h = $urandom_range(60, 1);
				idle_in = $urandom_range(50); stall_out = $urandom_range(50);
			end
			endcase

			drain();
			// phase knobs change on the rising edge, away from the negedge readers
			@(posedge clk);
			send_idle_pct  = idle_in;
			recv_stall_pct = stall_out;
			hold_cycles    = hold;
			@(negedge clk);
			write_reg(REG_WIDTH, 15'(w));
			write_reg(REG_HEIGHT, 15'(h));

			if (ph == 0) begin
				// field extremes
				send_byte_at(8'h00, 15'd0, 15'd0);
				send_byte_at(8'hFF, 15'h7FFF, 15'h7FFF);
				// ESC not followed by '[' is dropped
				send_byte(CH_ESC);
				send_byte(8'h78);
				// ESC ESC '[' re-arms, then save cursor at the far column
				send_byte(CH_ESC);
				send_byte(CH_ESC);
				send_byte(CH_LBRK);
				send_byte_at(CH_SAVE, 15'h7FFF, 15'd0);
				send_csi($sformatf("%c", CH_REST));
				send_csi($sformatf("2%c", CH_ERASE));
				// underscore then a background color that clears it again
				send_csi($sformatf("%0d%c%0d%c", SGR_UNDER, CH_SEMI, SGR_BG_LO + 1, CH_SGR));
			end

			phase_start = bytes_sent;
			while (bytes_sent - phase_start < PHASE_BYTES)
				send_random_sequence();
			in_valid <= 1'b0;
		end

		drain();
		$display("covered %0d bytes over %0d screen sizes and idle mixes, with a %0d-cycle output hold",
			bytes_sent, NUM_PHASES, HOLD_LEN);
		$display("results: %0d prints, %0d attribute sets, %0d cursor moves, %0d clears",
			sb.per_action[ACT_PRINT], sb.per_action[ACT_ATTR],
			sb.per_action[ACT_MOVE], sb.per_action[ACT_CLEAR]);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
